[design/char_lcd_nibble_bus_sequencer_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the character LCD nibble bus sequencer
// Shared concurrent assertion forms, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_BUS_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_BUS_SEQUENCER_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define CLNS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define CLNS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/clns_pkg.sv]
// ---------------------------------------------------------------------------
// clns_pkg
// Types, constants, microcode and tables shared by the sequencer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package clns_pkg;

    // Request kinds carried on the input tuser.
    typedef enum logic [1:0] {
        FUNC_INIT = 2'd0,
        FUNC_CMD  = 2'd1,
        FUNC_CHAR = 2'd2,
        FUNC_GOTO = 2'd3
    } t_func;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_STROBE_WAIT   = 2'd0,
        REG_POWER_UP_WAIT = 2'd1
    } t_reg_idx;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned WAIT_W     = 10;

    localparam logic [7:0]        STROBE_WAIT_RST   = 8'd5;
    localparam logic [WAIT_W-1:0] POWER_UP_WAIT_RST = 10'd100;

    localparam logic [7:0] GOTO_BASE   = 8'h80;
    localparam logic [5:0] LINE_OFFSET = 6'd40;

    // Micro-operation performed on the pins by one step.
    typedef enum logic [1:0] {
        UOP_PWRUP = 2'd0,
        UOP_EN_HI = 2'd1,
        UOP_DATA  = 2'd2,
        UOP_EN_LO = 2'd3
    } t_uop;

    // Sequencing: fall through to the target, or close the byte routine.
    typedef enum logic {
        SEQ_NEXT = 1'b0,
        SEQ_END  = 1'b1
    } t_seq;

    typedef struct packed {
        t_uop       kind;
        logic       nib_lo;
        t_seq       seq;
        logic [2:0] target;
    } t_uword;

    // Control handed from the sequencer to the datapath for the current step.
    typedef struct packed {
        t_uop kind;
        logic nib_lo;
        logic init_sel;
        logic last;
    } t_ctrl;

    localparam logic [2:0] ROM_INIT      = 3'd0;
    localparam logic [2:0] ROM_BYTE      = 3'd1;
    localparam logic [2:0] LAST_INIT_IDX = 3'd6;

    // Microprogram: a power-up step, then a six-step byte routine.
    function automatic t_uword ucode(input logic [2:0] pc);
        t_uword w;
        unique case (pc)
            3'd0:    w = '{kind: UOP_PWRUP, nib_lo: 1'b0, seq: SEQ_NEXT, target: 3'd1};
            3'd1:    w = '{kind: UOP_EN_HI, nib_lo: 1'b0, seq: SEQ_NEXT, target: 3'd2};
            3'd2:    w = '{kind: UOP_DATA,  nib_lo: 1'b0, seq: SEQ_NEXT, target: 3'd3};
            3'd3:    w = '{kind: UOP_EN_LO, nib_lo: 1'b0, seq: SEQ_NEXT, target: 3'd4};
            3'd4:    w = '{kind: UOP_EN_HI, nib_lo: 1'b1, seq: SEQ_NEXT, target: 3'd5};
            3'd5:    w = '{kind: UOP_DATA,  nib_lo: 1'b1, seq: SEQ_NEXT, target: 3'd6};
            3'd6:    w = '{kind: UOP_EN_LO, nib_lo: 1'b1, seq: SEQ_END,  target: ROM_BYTE};
            default: w = '{kind: UOP_EN_LO, nib_lo: 1'b1, seq: SEQ_END,  target: ROM_BYTE};
        endcase
        return w;
    endfunction

    // Fixed command bytes of the initialisation run.
    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'b0011_0011;
            3'd1:    b = 8'b0011_0010;
            3'd2:    b = 8'b0010_1000;
            3'd3:    b = 8'b0000_1000;
            3'd4:    b = 8'b0000_0001;
            3'd5:    b = 8'b0000_0110;
            3'd6:    b = 8'b0000_1100;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [3:0] rev4(input logic [3:0] n);
        return {n[0], n[1], n[2], n[3]};
    endfunction

endpackage

`default_nettype wire

[design/clns_useq.sv]
// ---------------------------------------------------------------------------
// clns_useq
// Step counter, microcode lookup and loop control over the init bytes.
// ---------------------------------------------------------------------------
`default_nettype none

module clns_useq
    import clns_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic       i_init,
    input  wire logic       i_adv,
    output t_ctrl           o_ctrl,
    output logic [2:0]      o_bcnt,
    output logic            o_busy
);

    logic       r_busy, n_busy;
    logic       r_init, n_init;
    logic [2:0] r_pc,   n_pc;
    logic [2:0] r_bcnt, n_bcnt;
    t_uword     w_word;
    logic       w_more;

    assign w_word = ucode(r_pc);
    // Another init byte still follows the one now finishing.
    assign w_more = r_init && (r_bcnt != LAST_INIT_IDX);

    always_comb begin
        n_busy = r_busy;
        n_init = r_init;
        n_pc   = r_pc;
        n_bcnt = r_bcnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_init = i_init;
            n_pc   = i_init ? ROM_INIT : ROM_BYTE;
            n_bcnt = 3'd0;
        end else if (i_adv) begin
            n_pc = w_word.target;
            if (w_word.seq == SEQ_END) begin
                if (w_more) begin
                    n_bcnt = r_bcnt + 3'd1;
                end else begin
                    n_busy = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_init <= 1'b0;
            r_pc   <= ROM_INIT;
            r_bcnt <= 3'd0;
        end else begin
            r_busy <= n_busy;
            r_init <= n_init;
            r_pc   <= n_pc;
            r_bcnt <= n_bcnt;
        end
    end

    assign o_ctrl.kind     = w_word.kind;
    assign o_ctrl.nib_lo   = w_word.nib_lo;
    assign o_ctrl.init_sel = r_init;
    assign o_ctrl.last     = (w_word.seq == SEQ_END) && !w_more;
    assign o_bcnt          = r_bcnt;
    assign o_busy          = r_busy;

endmodule

`default_nettype wire

[design/clns_dpath.sv]
// ---------------------------------------------------------------------------
// clns_dpath
// Pin levels, byte selection and the registered output event.
// ---------------------------------------------------------------------------
`default_nettype none

module clns_dpath
    import clns_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire t_func             i_func,
    input  wire logic [7:0]        i_value,
    input  wire logic              i_line,
    input  wire logic [5:0]        i_col,
    input  wire logic              i_adv,
    input  wire t_ctrl             i_ctrl,
    input  wire logic [2:0]        i_bcnt,
    input  wire logic [7:0]        i_strobe_wait,
    input  wire logic [WAIT_W-1:0] i_power_up_wait,
    input  wire logic              i_out_ready,
    output logic                   o_valid,
    output logic                   o_rs,
    output logic                   o_en,
    output logic [3:0]             o_nib,
    output logic [WAIT_W-1:0]      o_wait,
    output logic                   o_last
);

    logic              r_rs, r_en, n_en;
    logic [3:0]        r_nib, n_nib;
    logic [7:0]        r_byte, n_byte;
    logic              r_valid;
    logic              r_o_rs, r_o_en, r_o_last;
    logic [3:0]        r_o_nib;
    logic [WAIT_W-1:0] r_o_wait, n_wait;
    logic [7:0]        w_cur;
    logic [3:0]        w_nib;
    logic [5:0]        w_addr;

    assign w_addr = i_col + (i_line ? LINE_OFFSET : 6'd0);

    always_comb begin
        unique case (i_func)
            FUNC_GOTO: n_byte = GOTO_BASE | {2'b00, w_addr};
            FUNC_INIT,
            FUNC_CMD,
            FUNC_CHAR: n_byte = i_value;
            default:   n_byte = i_value;
        endcase
    end

    assign w_cur = i_ctrl.init_sel ? init_byte(i_bcnt) : r_byte;
    assign w_nib = i_ctrl.nib_lo ? w_cur[3:0] : w_cur[7:4];

    always_comb begin
        n_en   = r_en;
        n_nib  = r_nib;
        n_wait = {{(WAIT_W-8){1'b0}}, i_strobe_wait};
        unique case (i_ctrl.kind)
            UOP_PWRUP: begin
                n_en   = 1'b0;
                n_wait = i_power_up_wait;
            end
            UOP_EN_HI: n_en  = 1'b1;
            UOP_DATA:  n_nib = rev4(w_nib);
            UOP_EN_LO: n_en  = 1'b0;
            default:   n_en  = r_en;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs    <= 1'b0;
            r_en    <= 1'b0;
            r_nib   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            if (i_start) begin
                r_rs <= (i_func == FUNC_CHAR);
            end
            if (i_adv) begin
                r_en    <= n_en;
                r_nib   <= n_nib;
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_byte <= n_byte;
        end
        if (i_adv) begin
            r_o_rs   <= r_rs;
            r_o_en   <= n_en;
            r_o_nib  <= n_nib;
            r_o_wait <= n_wait;
            r_o_last <= i_ctrl.last;
        end
    end

    assign o_valid = r_valid;
    assign o_rs    = r_o_rs;
    assign o_en    = r_o_en;
    assign o_nib   = r_o_nib;
    assign o_wait  = r_o_wait;
    assign o_last  = r_o_last;

endmodule

`default_nettype wire

[design/char_lcd_nibble_bus_sequencer.sv]
// ---------------------------------------------------------------------------
// char_lcd_nibble_bus_sequencer
// Turns LCD requests into a stream of timed pin events for a 4-bit bus.
// ---------------------------------------------------------------------------
// Usage: each transfer on the slave stream is one request (tuser selects
// init, command byte, character byte or cursor goto). The master stream
// carries one pin event per transfer: register select, enable level, the
// bit-reversed nibble on the bus and the wait in milliseconds that must
// follow it; tlast marks the final event of the request. Waiting is left to
// the receiver.
// Throughput: a microcoded sequencer steps through one control word per
// cycle unless the master side stalls, so one event is produced per cycle.
// The request is first loaded into the sequencer state and the first event
// is then registered in the output register. Init runs 43 steps and every
// other request six, and the next request is taken in the cycle after the
// last event is registered.
// Stalls: while the master side holds tready low the step counter freezes and
// the pending event is held in the output register.
// Reset: synchronous, active low. Pin state clears to zero, the waits return
// to 5 ms (strobe) and 100 ms (power-up). The user must write configuration only
// while no request is in progress; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_bus_sequencer
    import clns_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Request stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [15:0]           s_axis_tdata,  // value[7:0], line[8], col[14:9]
    input  wire logic [1:0]            s_axis_tuser,  // func[1:0]
    // Pin event stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [15:0]                m_axis_tdata,  // enable[0], bus_nibble[4:1],
                                                      // wait_ms[14:5]
    output logic                       m_axis_tuser,  // reg_select
    output logic                       m_axis_tlast
);

`include "char_lcd_nibble_bus_sequencer_defines.svh"

    logic [7:0]        r_strobe_wait;
    logic [WAIT_W-1:0] r_power_up_wait;

    logic              w_accept;
    logic              w_adv;
    logic              w_busy;
    t_ctrl             w_ctrl;
    logic [2:0]        w_bcnt;
    t_func             w_func;
    logic              w_en;
    logic [3:0]        w_nib;
    logic [WAIT_W-1:0] w_wait;

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe_wait   <= STROBE_WAIT_RST;
            r_power_up_wait <= POWER_UP_WAIT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_STROBE_WAIT) begin
                r_strobe_wait <= i_cfg_wdata[7:0];
            end
            if (i_cfg_idx == REG_POWER_UP_WAIT) begin
                r_power_up_wait <= i_cfg_wdata;
            end
        end
    end

    // A request is taken whenever the sequencer is idle, even if the last
    // event of the previous request is still waiting in the output register.
    assign s_axis_tready = !w_busy;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_func        = t_func'(s_axis_tuser);

    // A step runs when the output register is empty or is being emptied.
    assign w_adv = w_busy && (!m_axis_tvalid || m_axis_tready);

    clns_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_init  (w_func == FUNC_INIT),
        .i_adv   (w_adv),
        .o_ctrl  (w_ctrl),
        .o_bcnt  (w_bcnt),
        .o_busy  (w_busy)
    );

    clns_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_accept),
        .i_func          (w_func),
        .i_value         (s_axis_tdata[7:0]),
        .i_line          (s_axis_tdata[8]),
        .i_col           (s_axis_tdata[14:9]),
        .i_adv           (w_adv),
        .i_ctrl          (w_ctrl),
        .i_bcnt          (w_bcnt),
        .i_strobe_wait   (r_strobe_wait),
        .i_power_up_wait (r_power_up_wait),
        .i_out_ready     (m_axis_tready),
        .o_valid         (m_axis_tvalid),
        .o_rs            (m_axis_tuser),
        .o_en            (w_en),
        .o_nib           (w_nib),
        .o_wait          (w_wait),
        .o_last          (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_wait, w_nib, w_en};

    // Every run finishes with the enable strobe low.
    `CLNS_ASSERT_SAME(a_last_enable_low, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tlast, !m_axis_tdata[0],
        "final event of a run left the enable strobe high")

    // Once a request is taken, no further request is taken until it is done.
    `CLNS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        w_accept, !s_axis_tready,
        "request accepted while the previous one was starting")

    // The init byte counter never runs past the seventh byte.
    `CLNS_ASSERT_SAME(a_bcnt_bound, i_clk, i_rst_n,
        w_busy, w_bcnt <= LAST_INIT_IDX,
        "init byte counter out of range")

endmodule

`default_nettype wire
